[rtl/core/bros_pkg.sv]
// shared types and constants for the border ring occlusion subtract block
package bros_pkg;

    // coordinate width of every edge field
    localparam int COORD_BITS = 16;

    // configuration register file
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_SEL_W = 3;

    localparam logic [CFG_SEL_W-1:0] CFG_OUTER_LEFT   = 3'd0;
    localparam logic [CFG_SEL_W-1:0] CFG_OUTER_TOP    = 3'd1;
    localparam logic [CFG_SEL_W-1:0] CFG_OUTER_RIGHT  = 3'd2;
    localparam logic [CFG_SEL_W-1:0] CFG_OUTER_BOTTOM = 3'd3;
    localparam logic [CFG_SEL_W-1:0] CFG_INNER_LEFT   = 3'd4;
    localparam logic [CFG_SEL_W-1:0] CFG_INNER_TOP    = 3'd5;
    localparam logic [CFG_SEL_W-1:0] CFG_INNER_RIGHT  = 3'd6;
    localparam logic [CFG_SEL_W-1:0] CFG_INNER_BOTTOM = 3'd7;

    // request kinds
    localparam logic REQ_OCCLUDE = 1'b0;
    localparam logic REQ_EMIT    = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // one half-open rectangle, right and bottom exclusive
    typedef struct packed {
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
    } box_t;

    typedef struct packed {
        logic   req_type;
        coord_t occ_left;
        coord_t occ_top;
        coord_t occ_right;
        coord_t occ_bottom;
    } req_t;

    typedef struct packed {
        coord_t seg_left;
        coord_t seg_top;
        coord_t seg_right;
        coord_t seg_bottom;
        logic   none_visible;
        logic   overflowed;
        logic   last_segment;
    } res_t;

endpackage

[rtl/core/bros_ram.sv]
// generic single-write, single-read ram with registered read data
module bros_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/border_ring_occlusion_subtract.sv]
// top level: visible segment list of a border ring under rectangular occluders
//
// A request is taken when start is high and busy is low; busy stays high until
// all of its work and results are done. The segment list lives in one ram
// split into two banks of MAX_SEGMENTS entries: an occluder reads every stored
// segment from the current bank and writes the surviving pieces to the other
// bank, then the banks swap, so a read and a write never touch the same entry.
// The first request after reset or after an emit rebuilds the ring from the
// configuration registers in S_RING, one piece slot per ring piece. An occluder
// passes S_DISPATCH and then, per stored segment, one read, one latch step and
// four piece slots on the single write port. An emit reads each stored segment,
// or gives one result with none_visible set for an empty list; results come one
// per cycle on res with res_strobe high for exactly one cycle each and cannot be
// held off. Configuration writes are taken only while the block is idle.
module border_ring_occlusion_subtract
    import bros_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  res_strobe,
    output res_t                  res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  coord_t                cfg_data
);

    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int BOX_W  = $bits(box_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RING,
        S_DISPATCH,
        S_OCC_RD,
        S_OCC_LAT,
        S_OCC_PUT,
        S_EMIT,
        S_TAIL
    } state_t;

    state_t            state_reg;
    coord_t            cfg_reg [CFG_NUM];
    req_t              op_reg;
    box_t              seg_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  new_n_reg;
    logic [CNT_W-1:0]  new_n_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [1:0]        k_reg;
    logic              bank_reg;
    logic              fresh_reg;
    logic              ovf_reg;
    logic              strobe_reg;
    logic              none_reg;
    logic              last_reg;

    box_t              cand [4];
    logic [3:0]        cval;
    box_t              occ_box;
    coord_t            mid_t;
    coord_t            mid_b;

    logic              ring_mode;
    logic              put_active;
    logic [CNT_W-1:0]  put_n;
    logic              put_full;
    logic              put_we;
    logic              put_drop;
    logic              idx_last;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [BOX_W-1:0]  rd_data;
    box_t              rd_box;

    function automatic coord_t smin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t smax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic box_empty(input box_t x);
        return (x.r <= x.l) || (x.b <= x.t);
    endfunction

    function automatic logic box_hits(input box_t a, input box_t h);
        return (a.l < h.r) && (h.l < a.r) && (a.t < h.b) && (h.t < a.b);
    endfunction

    // segment list in two banks
    bros_ram #(
        .WIDTH (BOX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (put_we),
        .wr_addr (wr_addr),
        .wr_data (cand[k_reg]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_box = box_t'(rd_data);

    assign occ_box.l = op_reg.occ_left;
    assign occ_box.t = op_reg.occ_top;
    assign occ_box.r = op_reg.occ_right;
    assign occ_box.b = op_reg.occ_bottom;

    assign mid_t = smax(seg_reg.t, occ_box.t);
    assign mid_b = smin(seg_reg.b, occ_box.b);

    // candidate pieces: ring pieces while building, else split of the latched segment
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cand[i] = '0;
        end
        cval = '0;
        if (ring_mode)
        begin
            cand[0] = '{cfg_reg[CFG_OUTER_LEFT], cfg_reg[CFG_OUTER_TOP],
                        cfg_reg[CFG_OUTER_RIGHT], cfg_reg[CFG_INNER_TOP]};
            cand[1] = '{cfg_reg[CFG_OUTER_LEFT], cfg_reg[CFG_INNER_BOTTOM],
                        cfg_reg[CFG_OUTER_RIGHT], cfg_reg[CFG_OUTER_BOTTOM]};
            cand[2] = '{cfg_reg[CFG_OUTER_LEFT], cfg_reg[CFG_INNER_TOP],
                        cfg_reg[CFG_INNER_LEFT], cfg_reg[CFG_INNER_BOTTOM]};
            cand[3] = '{cfg_reg[CFG_INNER_RIGHT], cfg_reg[CFG_INNER_TOP],
                        cfg_reg[CFG_OUTER_RIGHT], cfg_reg[CFG_INNER_BOTTOM]};
            for (int i = 0; i < 4; i++)
            begin
                cval[i] = !box_empty(cand[i]);
            end
        end
        else if (!box_empty(seg_reg))
        begin
            if (!box_hits(seg_reg, occ_box))
            begin
                cand[0] = seg_reg;
                cval[0] = 1'b1;
            end
            else
            begin
                cand[0] = '{seg_reg.l, seg_reg.t, seg_reg.r, smin(seg_reg.b, occ_box.t)};
                cand[1] = '{seg_reg.l, smax(seg_reg.t, occ_box.b), seg_reg.r, seg_reg.b};
                cand[2] = '{seg_reg.l, mid_t, smin(seg_reg.r, occ_box.l), mid_b};
                cand[3] = '{smax(seg_reg.l, occ_box.r), mid_t, seg_reg.r, mid_b};
                cval[0] = !box_empty(cand[0]);
                cval[1] = !box_empty(cand[1]);
                cval[2] = (mid_t < mid_b) && !box_empty(cand[2]);
                cval[3] = (mid_t < mid_b) && !box_empty(cand[3]);
            end
        end
    end

    // piece write path, drop and flag when the target list is full
    assign ring_mode  = (state_reg == S_RING);
    assign put_active = ring_mode || (state_reg == S_OCC_PUT);
    assign put_n      = ring_mode ? count_reg : new_n_reg;
    assign put_full   = (put_n >= CNT_W'(MAX_SEGMENTS));
    assign put_we     = put_active && cval[k_reg] && !put_full;
    assign put_drop   = put_active && cval[k_reg] && put_full;
    assign wr_addr    = {(ring_mode ? bank_reg : ~bank_reg), put_n[IDX_W-1:0]};
    assign new_n_next = new_n_reg + CNT_W'(put_we && !ring_mode);

    // read path, current bank only
    assign rd_en    = (state_reg == S_OCC_RD) || (state_reg == S_EMIT);
    assign rd_addr  = {bank_reg, idx_reg[IDX_W-1:0]};
    assign idx_last = ((idx_reg + CNT_W'(1)) == count_reg);

    // control state and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            new_n_reg  <= '0;
            idx_reg    <= '0;
            k_reg      <= '0;
            bank_reg   <= 1'b0;
            fresh_reg  <= 1'b1;
            ovf_reg    <= 1'b0;
            strobe_reg <= 1'b0;
            none_reg   <= 1'b0;
            last_reg   <= 1'b0;
            for (int i = 0; i < CFG_NUM; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(CFG_NUM)))
            begin
                cfg_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
            end
            if (put_drop)
            begin
                ovf_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        k_reg <= '0;
                        if (fresh_reg)
                        begin
                            count_reg <= '0;
                            state_reg <= S_RING;
                        end
                        else
                        begin
                            state_reg <= S_DISPATCH;
                        end
                    end
                end
                S_RING:
                begin
                    if (put_we)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        fresh_reg <= 1'b0;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    idx_reg   <= '0;
                    new_n_reg <= '0;
                    if (op_reg.req_type == REQ_EMIT)
                    begin
                        if (count_reg == '0)
                        begin
                            strobe_reg <= 1'b1;
                            none_reg   <= 1'b1;
                            last_reg   <= 1'b1;
                            state_reg  <= S_TAIL;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_OCC_RD;
                    end
                end
                S_OCC_RD:
                begin
                    state_reg <= S_OCC_LAT;
                end
                S_OCC_LAT:
                begin
                    k_reg     <= '0;
                    state_reg <= S_OCC_PUT;
                end
                S_OCC_PUT:
                begin
                    new_n_reg <= new_n_next;
                    k_reg     <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        if (idx_last)
                        begin
                            count_reg <= new_n_next;
                            bank_reg  <= ~bank_reg;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CNT_W'(1);
                            state_reg <= S_OCC_RD;
                        end
                    end
                end
                S_EMIT:
                begin
                    strobe_reg <= 1'b1;
                    none_reg   <= 1'b0;
                    last_reg   <= idx_last;
                    idx_reg    <= idx_reg + CNT_W'(1);
                    if (idx_last)
                    begin
                        state_reg <= S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    count_reg <= '0;
                    fresh_reg <= 1'b1;
                    ovf_reg   <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request and segment holding registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            op_reg <= req;
        end
        if (state_reg == S_OCC_LAT)
        begin
            seg_reg <= rd_box;
        end
    end

    // outputs
    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign res_strobe = strobe_reg;

    always_comb
    begin
        res.seg_left     = none_reg ? coord_t'(0) : rd_box.l;
        res.seg_top      = none_reg ? coord_t'(0) : rd_box.t;
        res.seg_right    = none_reg ? coord_t'(0) : rd_box.r;
        res.seg_bottom   = none_reg ? coord_t'(0) : rd_box.b;
        res.none_visible = none_reg;
        res.overflowed   = ovf_reg;
        res.last_segment = last_reg;
    end

    // checks
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> busy)
        else $error("result strobe outside a request");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond capacity");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && res.none_visible) |-> res.last_segment)
        else $error("empty-list result not marked last");

    a_tail_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAIL) |=> (fresh_reg && (count_reg == '0) && !ovf_reg))
        else $error("list not restarted after emit");

endmodule
